[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

[src/nfbsc_pkg.sv]
package nfbsc_pkg;

  localparam int BYTE_W      = 8;
  localparam int NIB_W       = 4;
  localparam int BLOCK_BYTES = 16;
  localparam int IDX_W       = $clog2(BLOCK_BYTES);
  localparam int RND_W       = 4;

  // in-band command bytes
  localparam logic [BYTE_W-1:0] CMD_KEY    = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_STREAM = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_STOP   = 8'h03;
  localparam logic [BYTE_W-1:0] CMD_INDEX  = 8'h0f;

  typedef struct packed {
    logic             load;    // input beat taken this cycle
    logic             step;    // run one Feistel round
    logic             commit;  // store enciphered byte, maybe emit
    logic [RND_W-1:0] rnd;     // current round number
  } ctrl_cmd_t;

  typedef struct packed {
    logic data;      // incoming beat is a stream data byte
    logic out_busy;  // output register full and not being taken
  } ctrl_sts_t;

  function automatic logic [NIB_W-1:0] nib_rotl1(input logic [NIB_W-1:0] x);
    return {x[NIB_W-2:0], x[NIB_W-1]};
  endfunction

  // F(R,K) = ((R + K) mod 16) xor rotl1(R)
  function automatic logic [NIB_W-1:0] round_f(input logic [NIB_W-1:0] r,
                                                input logic [NIB_W-1:0] k);
    logic [NIB_W-1:0] s;
    s = r + k;
    return s ^ nib_rotl1(r);
  endfunction

endpackage

[src/nibble_feistel_byte_stream_cipher_core.sv]
// Byte stream cipher driven by in-band commands on the input stream. While idle,
// 0x01 loads the next 16 beats as key bytes, 0x0f takes the low nibble of the next
// beat as start index, and 0x02 enters stream mode; in stream mode 0x03 returns
// to idle and drops pending output, every other beat is a data byte. Each data
// byte is enciphered with a ROUNDS-round nibble Feistel network, one round per
// clock in a single shared round unit, so a data beat holds the input through
// its load, every round and its commit (longer while the output register is held
// full), a command beat only through its load. Output starts with the beat that
// completes a 16-byte block and then gives one byte of that block per following
// data beat. The output register lets the next beat be taken while a result waits.
module nibble_feistel_byte_stream_cipher_core #(
  parameter int ROUNDS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [nfbsc_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] in_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [nfbsc_pkg::BYTE_W-1:0]  m_tdata    // [7:0] enc_byte
);
  import nfbsc_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  nfbsc_ctrl #(
    .ROUNDS (ROUNDS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nfbsc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

[src/nfbsc_ctrl.sv]
`include "assert_macros.svh"

module nfbsc_ctrl #(
  parameter int ROUNDS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  nfbsc_pkg::ctrl_sts_t  sts,
  output nfbsc_pkg::ctrl_cmd_t  cmd
);
  import nfbsc_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ROUND  = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);

  logic [1:0]       state, state_next;
  logic [RND_W-1:0] rnd, rnd_next;

  always_comb begin
    s_tready   = (state == S_IDLE);
    cmd.load   = s_tvalid && (state == S_IDLE);
    cmd.step   = (state == S_ROUND);
    cmd.commit = (state == S_COMMIT) && !sts.out_busy;
    cmd.rnd    = rnd;
    state_next = state;
    rnd_next   = rnd;
    case (state)
      S_IDLE: begin
        rnd_next = '0;
        if (cmd.load && sts.data) state_next = S_ROUND;
      end
      S_ROUND: begin
        rnd_next = rnd + 1'b1;
        if (rnd == LAST_RND) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (cmd.commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rnd   <= '0;
    end else begin
      state <= state_next;
      rnd   <= rnd_next;
    end
  end

  `ASSERT_PROP(a_data_starts_rounds, clk, rst, (cmd.load && sts.data) |=> (state == S_ROUND))
  `ASSERT_PROP(a_last_round_commits, clk, rst,
               (state == S_ROUND && rnd == LAST_RND) |=> (state == S_COMMIT))
  `ASSERT_NEVER(a_no_commit_when_busy, clk, rst, cmd.commit && sts.out_busy)

endmodule

[src/nfbsc_dp.sv]
`include "assert_macros.svh"

module nfbsc_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [nfbsc_pkg::BYTE_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [nfbsc_pkg::BYTE_W-1:0]  m_tdata,
  input  nfbsc_pkg::ctrl_cmd_t          cmd,
  output nfbsc_pkg::ctrl_sts_t          sts
);
  import nfbsc_pkg::*;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_KEY    = 2'd1;
  localparam logic [1:0] MODE_INDEX  = 2'd2;
  localparam logic [1:0] MODE_STREAM = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_BYTES - 1);
  localparam logic [IDX_W-1:0] DRAIN_END = IDX_W'(BLOCK_BYTES - 2);

  logic [1:0]        mode;
  logic [BYTE_W-1:0] key_store [BLOCK_BYTES];
  logic [IDX_W-1:0]  key_count;
  logic [NIB_W-1:0]  start_nibble;
  logic [IDX_W-1:0]  key_position;
  logic [IDX_W-1:0]  in_count;
  logic              out_pending;
  // enciphered bytes, stored as they arrive; one block drains while the next fills
  logic [BYTE_W-1:0] enc_buf [BLOCK_BYTES];

  logic [NIB_W-1:0]  lft, rgt, khi;
  logic [NIB_W-1:0]  rnd_key, f_val;
  logic [IDX_W-1:0]  key_idx, rd_idx;
  logic              emit;

  assign sts.data     = (mode == MODE_STREAM) && (s_tdata != CMD_STOP);
  assign sts.out_busy = m_tvalid && !m_tready;

  always_comb begin
    rnd_key = (start_nibble + cmd.rnd) ^ khi;
    f_val   = round_f(rgt, rnd_key);
    key_idx = key_position + in_count;
    rd_idx  = in_count + 1'b1;
    emit    = (in_count == LAST_IDX) || out_pending;
  end

  // control state and key store
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      key_count    <= '0;
      start_nibble <= '0;
      key_position <= '0;
      in_count     <= '0;
      out_pending  <= 1'b0;
      m_tvalid     <= 1'b0;
      for (int i = 0; i < BLOCK_BYTES; i++) key_store[i] <= '0;
    end else begin
      if (cmd.commit && emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (cmd.load) begin
        case (mode)
          MODE_IDLE: begin
            if (s_tdata == CMD_KEY) begin
              mode      <= MODE_KEY;
              key_count <= '0;
            end else if (s_tdata == CMD_INDEX) begin
              mode <= MODE_INDEX;
            end else if (s_tdata == CMD_STREAM) begin
              mode        <= MODE_STREAM;
              in_count    <= '0;
              out_pending <= 1'b0;
            end
          end
          MODE_KEY: begin
            key_store[key_count] <= s_tdata;
            if (key_count == LAST_IDX) mode <= MODE_IDLE;
            key_count <= key_count + 1'b1;
          end
          MODE_INDEX: begin
            start_nibble <= s_tdata[NIB_W-1:0];
            key_position <= s_tdata[IDX_W-1:0];
            mode         <= MODE_IDLE;
          end
          MODE_STREAM: begin
            if (s_tdata == CMD_STOP) begin
              mode        <= MODE_IDLE;
              in_count    <= '0;
              out_pending <= 1'b0;
            end
          end
          default: mode <= MODE_IDLE;
        endcase
      end
      if (cmd.commit) begin
        in_count    <= in_count + 1'b1;
        // drain of a block ends on the beat before the next block completes
        out_pending <= (in_count == LAST_IDX) || (out_pending && in_count != DRAIN_END);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lft <= s_tdata[BYTE_W-1:NIB_W];
      rgt <= s_tdata[NIB_W-1:0];
      khi <= key_store[key_idx][BYTE_W-1:NIB_W];
    end else if (cmd.step) begin
      lft <= rgt;
      rgt <= lft ^ f_val;
    end
    if (cmd.commit) begin
      enc_buf[in_count] <= {lft, rgt};
      if (emit) m_tdata <= enc_buf[rd_idx];
    end
  end

  `ASSERT_PROP(a_valid_from_commit, clk, rst, $rose(m_tvalid) |-> $past(cmd.commit))
  `ASSERT_PROP(a_count_moves_on_cmd, clk, rst,
               !$stable(in_count) |-> $past(cmd.load || cmd.commit))
  `ASSERT_PROP(a_pending_in_stream, clk, rst, out_pending |-> (mode == MODE_STREAM))

endmodule
